[rtl/baeq_pkg.sv]
`timescale 1ns / 1ps

package baeq_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHORT_TICKS = 2'd0,
    CFG_LONG_TICKS  = 2'd1,
    CFG_ENC_STABLE  = 2'd2
  } cfg_index_t;

  localparam int TICKS_W  = 10;
  localparam int REPEAT_W = 4;
  localparam int CFG_W    = 10;

  localparam logic [TICKS_W-1:0]  TICKS_MAX         = 10'd1023;
  localparam logic [TICKS_W-1:0]  SHORT_TICKS_RESET = 10'd100;
  localparam logic [TICKS_W-1:0]  LONG_TICKS_RESET  = 10'd800;
  localparam logic [REPEAT_W-1:0] ENC_STABLE_RESET  = 4'd5;

  // encoder pin pair codes, {b, a}
  localparam logic [1:0] PAIR_00 = 2'b00;
  localparam logic [1:0] PAIR_01 = 2'b01;
  localparam logic [1:0] PAIR_10 = 2'b10;
  localparam logic [1:0] PAIR_11 = 2'b11;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRESSED = 3'd1,
    PH_HOLD    = 3'd2
  } press_phase_t;

  // detent sequence position
  typedef enum logic [3:0] {
    ENC_NONE = 4'd0,
    ENC_DN1  = 4'd1,
    ENC_DN2  = 4'd2,
    ENC_DN3  = 4'd3,
    ENC_UP1  = 4'd5,
    ENC_UP2  = 4'd6,
    ENC_UP3  = 4'd7
  } enc_phase_t;

  typedef struct packed {
    logic button_level;
    logic enc_a;
    logic enc_b;
  } sample_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic step_up;
    logic step_down;
  } result_t;

endpackage

[rtl/button_and_encoder_qualifier_core.sv]
`timescale 1ns / 1ps

// Button and quadrature encoder qualifier. Feed one sample word per sample
// tick: the active-low button level and the two encoder pins. Every sample
// word yields exactly one result word carrying short_press, long_press,
// step_up and step_down pulses. A word passes an input register and a result
// register before its result word is offered. One word can be accepted every
// cycle, limited only by stall on the result side, and at most two words are
// held inside. The press thresholds and the encoder stability count are set
// through the configuration write port (always ready), which should be used
// only while no words are in flight.
module button_and_encoder_qualifier_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  baeq_pkg::sample_t         sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output baeq_pkg::result_t         result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [baeq_pkg::CFG_W-1:0] cfg_data
);
  import baeq_pkg::*;

  // configuration
  logic [TICKS_W-1:0]  short_ticks;
  logic [TICKS_W-1:0]  long_ticks;
  logic [REPEAT_W-1:0] enc_stable;

  // qualifier state
  press_phase_t        press_phase, press_phase_next;
  logic [TICKS_W-1:0]  press_ticks, press_ticks_next;
  logic [1:0]          enc_accepted, enc_accepted_next;
  logic [1:0]          enc_candidate, enc_candidate_next;
  logic [REPEAT_W-1:0] enc_repeat, enc_repeat_next;
  enc_phase_t          enc_phase, enc_phase_next;

  // input stage
  logic    s1_valid;
  sample_t s1_word;

  logic    advance;
  logic    go;
  result_t result_next;

  logic               pressed;
  logic [1:0]         pair;
  logic [TICKS_W-1:0] ticks_inc;
  logic               enc_take;

  assign cfg_ready = 1'b1;

  // the pipeline moves when the result register is empty or being taken
  assign advance      = !result_valid || !result_stall;
  assign go           = s1_valid && advance;
  assign sample_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= SHORT_TICKS_RESET;
      long_ticks  <= LONG_TICKS_RESET;
      enc_stable  <= ENC_STABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHORT_TICKS: short_ticks <= cfg_data;
        CFG_LONG_TICKS:  long_ticks  <= cfg_data;
        CFG_ENC_STABLE:  enc_stable  <= cfg_data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_word <= sample;
    end
  end

  assign pressed   = !s1_word.button_level;
  assign pair      = {s1_word.enc_b, s1_word.enc_a};
  // saturating hold counter
  assign ticks_inc = (press_ticks < TICKS_MAX) ? press_ticks + 1'b1 : press_ticks;

  // button press qualifier, next state
  always_comb begin
    press_phase_next       = press_phase;
    press_ticks_next       = press_ticks;
    if (pressed) begin
      if (press_phase != PH_HOLD) begin
        press_phase_next = PH_PRESSED;
        press_ticks_next = ticks_inc;
        if (ticks_inc >= long_ticks) begin
          press_phase_next       = PH_HOLD;
          press_ticks_next       = '0;
        end
      end
    end else begin
      // count is kept on a short tap so taps add up
      if (press_phase == PH_PRESSED && press_ticks >= short_ticks) begin
        press_phase_next        = PH_HOLD;
        press_ticks_next        = '0;
      end else begin
        press_phase_next = PH_IDLE;
      end
    end
  end

  // encoder debounce and detent tracking, next state
  always_comb begin
    enc_accepted_next   = enc_accepted;
    enc_candidate_next  = enc_candidate;
    enc_repeat_next     = enc_repeat;
    enc_phase_next      = enc_phase;
    if (pair != enc_accepted) begin
      if (pair == enc_candidate) begin
        enc_repeat_next = enc_repeat + 1'b1;
      end else begin
        enc_repeat_next    = '0;
        enc_candidate_next = pair;
      end
      if (enc_repeat_next == enc_stable) begin
        enc_accepted_next = pair;
        // priority order matters: a fresh 10 or 01 restarts a sequence
        if (pair == PAIR_10 && enc_phase != ENC_UP2) begin
          enc_phase_next = ENC_DN1;
        end else if (pair == PAIR_01 && enc_phase != ENC_DN2) begin
          enc_phase_next = ENC_UP1;
        end else if (enc_phase == ENC_DN2 && pair == PAIR_01) begin
          enc_phase_next = ENC_DN3;
        end else if (enc_phase == ENC_UP1 && pair == PAIR_00) begin
          enc_phase_next = ENC_UP2;
        end else if (enc_phase == ENC_UP3 && pair == PAIR_11) begin
          enc_phase_next      = ENC_NONE;
        end else if (enc_phase == ENC_DN1 && pair == PAIR_00) begin
          enc_phase_next = ENC_DN2;
        end else if (enc_phase == ENC_DN3 && pair == PAIR_11) begin
          enc_phase_next        = ENC_NONE;
        end else if (enc_phase == ENC_UP2 && pair == PAIR_10) begin
          enc_phase_next = ENC_UP3;
        end else begin
          enc_phase_next = ENC_NONE;
        end
      end
    end
  end

  // a changed pair is taken once it has repeated often enough
  assign enc_take = (pair != enc_accepted) && (enc_repeat_next == enc_stable);

  // result pulses; a completed detent always ends on pair 11
  always_comb begin
    result_next.short_press = !pressed && press_phase == PH_PRESSED &&
                              press_ticks >= short_ticks;
    result_next.long_press  = pressed && press_phase != PH_HOLD && ticks_inc >= long_ticks;
    result_next.step_up     = enc_take && enc_phase == ENC_UP3 && pair == PAIR_11;
    result_next.step_down   = enc_take && enc_phase == ENC_DN3 && pair == PAIR_11;
  end

  // state advances once per processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      press_phase   <= PH_IDLE;
      press_ticks   <= '0;
      enc_accepted  <= '0;
      enc_candidate <= '0;
      enc_repeat    <= '0;
      enc_phase     <= ENC_NONE;
    end else if (go) begin
      press_phase   <= press_phase_next;
      press_ticks   <= press_ticks_next;
      enc_accepted  <= enc_accepted_next;
      enc_candidate <= enc_candidate_next;
      enc_repeat    <= enc_repeat_next;
      enc_phase     <= enc_phase_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result <= result_next;
    end
  end

endmodule

[rtl/baeq_checker.sv]
`timescale 1ns / 1ps

module baeq_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_stall,
  input logic              result_valid,
  input logic              result_stall,
  input baeq_pkg::result_t result
);
  import baeq_pkg::*;

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  // short and long press come from opposite button levels
  a_press_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.short_press && result.long_press))
    else $error("short and long press in one word");

  // a detent completes in only one direction
  a_step_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.step_up && result.step_down))
    else $error("step up and down in one word");

  // input stalls only behind a stalled result word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("input stalled with the result side free");

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind button_and_encoder_qualifier_core baeq_checker u_baeq_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import baeq_pkg::*;

  // generous bound on the whole run, in clock cycles
  localparam int CYCLE_LIMIT = 600000;
  // cap on printed mismatch lines, counting goes on
  localparam int MAX_PRINTS  = 40;
  // long receiver hold-off, long enough to back the block up
  localparam int HOLD_CYCLES = 120;

  // detent pair sequences {b, a}, first pair in the low bits
  localparam logic [7:0] UP_SEQ = {PAIR_11, PAIR_10, PAIR_00, PAIR_01};
  localparam logic [7:0] DN_SEQ = {PAIR_11, PAIR_01, PAIR_00, PAIR_10};

  // block ports, every input known from time zero
  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_stall;
  sample_t          sample       = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index    = '0;
  logic [CFG_W-1:0] cfg_data     = '0;

  // shadow copy of the threshold registers
  logic [TICKS_W-1:0]  lim_short  = SHORT_TICKS_RESET;
  logic [TICKS_W-1:0]  lim_long   = LONG_TICKS_RESET;
  logic [REPEAT_W-1:0] lim_stable = ENC_STABLE_RESET;

  // predicted button and encoder state, same reset values as the block
  press_phase_t        btn_phase = PH_IDLE;
  logic [TICKS_W-1:0]  btn_ticks = '0;
  logic [1:0]          enc_now   = PAIR_00;
  logic [1:0]          enc_cand  = PAIR_00;
  logic [REPEAT_W-1:0] enc_rep   = '0;
  enc_phase_t          detent    = ENC_NONE;

  // sample words waiting for the driver, and predicted result words
  sample_t pending[$];
  result_t expected_results[$];

  int errors    = 0;
  int cycles    = 0;
  int send_gap  = 0;
  int stall_gap = 0;
  int hold_left = 0;
  bit idle_on   = 1'b0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;

  button_and_encoder_qualifier_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // one tick of the qualifier: updates the predicted state, returns the pulses
  function automatic result_t qualify_sample(sample_t s);
    result_t    r;
    logic [1:0] pair;
    r    = '0;
    pair = {s.enc_b, s.enc_a};

    // button, active low
    if (!s.button_level) begin
      // held: count unless a press was already reported
      if (btn_phase != PH_HOLD) begin
        btn_phase = PH_PRESSED;
        if (btn_ticks != TICKS_MAX) btn_ticks++;
        if (btn_ticks >= lim_long) begin
          r.long_press = 1'b1;
          btn_phase    = PH_HOLD;
          btn_ticks    = '0;
        end
      end
    end else if (btn_phase == PH_PRESSED && btn_ticks >= lim_short) begin
      r.short_press = 1'b1;
      btn_phase     = PH_HOLD;
      btn_ticks     = '0;
    end else begin
      // short taps keep the count
      btn_phase = PH_IDLE;
    end

    // encoder: a changed pair must repeat lim_stable more times
    if (pair != enc_now) begin
      if (pair == enc_cand) begin
        enc_rep = enc_rep + 1'b1;
      end else begin
        enc_rep  = '0;
        enc_cand = pair;
      end
      if (enc_rep == lim_stable) begin
        enc_now = pair;
        if (pair == PAIR_10 && detent != ENC_UP2) detent = ENC_DN1;
        else if (pair == PAIR_01 && detent != ENC_DN2) detent = ENC_UP1;
        else if (detent == ENC_DN2 && pair == PAIR_01) detent = ENC_DN3;
        else if (detent == ENC_UP1 && pair == PAIR_00) detent = ENC_UP2;
        else if (detent == ENC_UP3 && pair == PAIR_11) begin
          detent    = ENC_NONE;
          r.step_up = 1'b1;
        end else if (detent == ENC_DN1 && pair == PAIR_00) detent = ENC_DN2;
        else if (detent == ENC_DN3 && pair == PAIR_11) begin
          detent      = ENC_NONE;
          r.step_down = 1'b1;
        end else if (detent == ENC_UP2 && pair == PAIR_10) detent = ENC_UP3;
        else detent = ENC_NONE;
      end
    end
    return r;
  endfunction

  function automatic string field_name(int k);
    case (k)
      3:       return "short_press";
      2:       return "long_press";
      1:       return "step_up";
      default: return "step_down";
    endcase
  endfunction

  task automatic report_mismatch(string what, result_t got, result_t want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch %s: got %b expected %b at %0t", what, got, want, $time);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result word", got, '0);
      return;
    end
    want = expected_results.pop_front();
    for (int k = 3; k >= 0; k--)
      if (got[k] !== want[k]) report_mismatch(field_name(k), got, want);
  endtask

  // driver: offers queued words, predicts each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (sample_valid && !sample_stall)
        expected_results.push_back(qualify_sample(sample));
      // a stalled word stays put
      if (!(sample_valid && sample_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          sample_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          // idle burst
          send_gap = $urandom_range(0, 8);
          sample_valid <= 1'b0;
        end else begin
          sample_valid <= 1'b1;
          sample       <= pending.pop_front();
        end
      end
    end
  end

  // monitor: checks taken result words, drives stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      // one long hold-off while the sender keeps offering words
      if (want_hold && !hold_done && result_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        result_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 8);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic push_n(bit btn, logic [1:0] pair, int n);
    sample_t w;
    w.button_level = btn;
    w.enc_a        = pair[0];
    w.enc_b        = pair[1];
    repeat (n) pending.push_back(w);
  endtask

  // four pairs of a detent, one sample each
  task automatic push_seq(bit btn, logic [7:0] seq);
    for (int k = 0; k < 4; k++) push_n(btn, seq[2*k +: 2], 1);
  endtask

  // mostly clean detents and presses, with glitches mixed in
  task automatic push_random(int n);
    bit         btn;
    bit         up;
    int         btn_left;
    int         enc_left;
    int         k;
    logic [1:0] pair;
    btn      = 1'b1;
    up       = 1'b0;
    btn_left = $urandom_range(1, 4);
    enc_left = 0;
    k        = 4;
    pair     = enc_now;
    repeat (n) begin
      if (enc_left == 0) begin
        if (k == 4) begin
          up = 1'($urandom_range(0, 1));
          k  = 0;
        end
        if ($urandom_range(0, 9) == 0) begin
          // bounce or stray pair
          pair     = 2'($urandom_range(0, 3));
          enc_left = $urandom_range(1, 3);
        end else begin
          pair     = up ? UP_SEQ[2*k +: 2] : DN_SEQ[2*k +: 2];
          k++;
          enc_left = int'(lim_stable) + 1 + $urandom_range(0, 2);
        end
      end
      push_n(btn, pair, 1);
      enc_left--;
      btn_left--;
      if (btn_left == 0) begin
        btn      = !btn;
        btn_left = btn ? $urandom_range(1, 6) : $urandom_range(1, int'(lim_long) + 3);
      end
    end
  endtask

  // call at a rising edge, returns at the edge the write lands
  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SHORT_TICKS: lim_short  = val[TICKS_W-1:0];
      CFG_LONG_TICKS:  lim_long   = val[TICKS_W-1:0];
      default:         lim_stable = val[REPEAT_W-1:0];
    endcase
  endtask

  task automatic set_limits(int s, int l, int e);
    write_reg(CFG_SHORT_TICKS, CFG_W'(s));
    write_reg(CFG_LONG_TICKS, CFG_W'(l));
    // junk in the unused upper bits of the stability count
    write_reg(CFG_ENC_STABLE, {6'($urandom_range(0, 63)), 4'(e)});
    cfg_valid <= 1'b0;
  endtask

  // sender pause: everything taken and every result back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || sample_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int s;
    int l;
    int e;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;

    // reset thresholds: a pair change waits five repeats
    push_n(1'b1, PAIR_01, 7);
    push_n(1'b0, PAIR_01, 3);
    push_n(1'b1, PAIR_01, 1);
    wait_idle();

    // small thresholds, pairs taken on their first sample
    set_limits(2, 4, 0);
    push_n(1'b1, PAIR_11, 1);
    push_seq(1'b1, UP_SEQ);
    // down detent with a short press on the release
    push_n(1'b0, PAIR_10, 1);
    push_n(1'b0, PAIR_00, 1);
    push_n(1'b1, PAIR_01, 1);
    push_n(1'b1, PAIR_11, 1);
    // long press, then hold until release
    push_n(1'b0, PAIR_11, 5);
    push_n(1'b1, PAIR_11, 1);
    // two taps below the short threshold add up
    push_n(1'b0, PAIR_11, 1);
    push_n(1'b1, PAIR_11, 1);
    push_n(1'b0, PAIR_11, 1);
    push_n(1'b1, PAIR_11, 1);
    wait_idle();

    // zero thresholds are met at once
    set_limits(0, 0, 0);
    push_n(1'b0, PAIR_11, 2);
    push_n(1'b1, PAIR_11, 1);
    push_n(1'b0, PAIR_00, 1);
    push_n(1'b1, PAIR_00, 1);
    wait_idle();

    // short threshold zero, and a repeat count left running
    set_limits(0, 3, 4);
    push_n(1'b0, PAIR_00, 1);
    push_n(1'b1, PAIR_10, 3);
    wait_idle();

    // stability lowered below the running count: waits for the wrap
    set_limits(0, 3, 1);
    push_n(1'b1, PAIR_10, 15);
    wait_idle();

    // top of every range
    set_limits(1023, 1023, 15);
    push_n(1'b0, PAIR_11, 40);
    push_n(1'b1, PAIR_11, 17);
    wait_idle();

    // random phases, the first one with the long hold-off
    want_hold = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      s = $urandom_range(1, 30);
      l = $urandom_range(1, 40);
      e = (ph == 3) ? 15 : $urandom_range(0, 4);
      set_limits(s, l, e);
      // no idling at all in the third and the last phase
      idle_on = (ph != 2 && ph != 5);
      push_random(125);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("result never arrived", '0, expected_results[0]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
